@@ rtl/bmsd_pkg.sv @@
package bmsd_pkg;

   localparam int ADC_FULL_SCALE_DEF = 1024;

   // register indexes on the csr port
   localparam logic [1:0] CSR_LOW_CELL  = 2'd0;
   localparam logic [1:0] CSR_MEASURE   = 2'd1;
   localparam logic [1:0] CSR_SCREEN    = 2'd2;

   localparam logic [10:0] LOW_CELL_RST = 11'd300;
   localparam logic [15:0] MEASURE_RST  = 16'd1500;
   localparam logic [15:0] SCREEN_RST   = 16'd1000;

   localparam logic [3:0] SCREEN_LAST = 4'd9;

   // screen codes
   localparam logic [3:0] SCR_ALL   = 4'd0;
   localparam logic [3:0] SCR_PACK  = 4'd1;
   localparam logic [3:0] SCR_CEL1  = 4'd2;
   localparam logic [3:0] SCR_CELL1 = 4'd3;
   localparam logic [3:0] SCR_CEL2  = 4'd4;
   localparam logic [3:0] SCR_CELL2 = 4'd5;
   localparam logic [3:0] SCR_CEL3  = 4'd6;
   localparam logic [3:0] SCR_CELL3 = 4'd7;
   localparam logic [3:0] SCR_ON    = 4'd8;
   localparam logic [3:0] SCR_NET   = 4'd9;

   // letter patterns, active high, bit2 is the decimal point
   localparam logic [7:0] SEG_DP    = 8'h04;
   localparam logic [7:0] SEG_A     = 8'hF9;
   localparam logic [7:0] SEG_L     = 8'h83;
   localparam logic [7:0] SEG_E     = 8'h9B;
   localparam logic [7:0] SEG_C     = 8'h8B;
   localparam logic [7:0] SEG_P     = 8'hD9;
   localparam logic [7:0] SEG_N     = 8'hE9;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   typedef struct packed {
      logic [3:0][7:0] seg;   // seg[0] is the leftmost digit
      logic [3:0]      mask;
   } disp_type;

   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'hEB;
         4'd1:    s = 8'h60;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h7A;
         4'd4:    s = 8'hF0;
         4'd5:    s = 8'hBA;
         4'd6:    s = 8'hBB;
         4'd7:    s = 8'hE8;
         4'd8:    s = 8'hFB;
         4'd9:    s = 8'hFA;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/bmsd_tap_conv.sv @@
// floor(raw * 2000 / ADC_FULL_SCALE) by an exact reciprocal multiply, saturated at 2047
module bmsd_tap_conv #(
   parameter int ADC_FULL_SCALE = bmsd_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic [9:0]  raw,
   output logic [10:0] cv
);
   // raw * 2000 stays below 2^21; shift of 21 + ceil(log2 d) makes the
   // rounded-up reciprocal exact over that range
   localparam int SHIFT = 21 + $clog2(ADC_FULL_SCALE);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
   localparam longint unsigned COEF = 64'd2000 * RECIP;
   localparam int COEF_W = $clog2(COEF + 64'd1);
   localparam int PROD_W = 10 + COEF_W;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] quot;

   assign prod = PROD_W'(raw) * PROD_W'(COEF);
   assign quot = prod >> SHIFT;
   assign cv   = (quot > PROD_W'(2047)) ? 11'd2047 : quot[10:0];

endmodule

@@ rtl/bmsd_display.sv @@
module bmsd_display (
   input  logic [3:0]         screen,
   input  logic signed [11:0] cell1,
   input  logic signed [11:0] cell2,
   input  logic signed [11:0] cell3,
   input  logic [10:0]        pack,
   input  logic               net_sw,
   output bmsd_pkg::disp_type disp
);
   logic signed [11:0] shown;
   logic [10:0] v;
   logic [22:0] ip_prod;
   logic [4:0]  ip;
   logic [6:0]  fr;
   logic [14:0] frt_prod;
   logic [3:0]  fr_tens;
   logic [3:0]  fr_ones;
   logic [3:0]  ip_tens;
   logic [3:0]  ip_ones;
   logic [12:0] ip_x100;
   logic [7:0]  ft_x10;
   bmsd_pkg::disp_type volts;

   always_comb begin
      case (screen)
         bmsd_pkg::SCR_CELL1: shown = cell1;
         bmsd_pkg::SCR_CELL2: shown = cell2;
         bmsd_pkg::SCR_CELL3: shown = cell3;
         default:             shown = {1'b0, pack};
      endcase
   end

   // negative cells read as zero
   assign v = shown[11] ? 11'd0 : shown[10:0];

   // v / 100 and v % 10 style splits by reciprocal multiply
   assign ip_prod  = 23'(v) * 23'd2622;
   assign ip       = ip_prod[22:18];
   assign ip_x100  = 13'(ip) * 13'd100;
   assign fr       = 7'(13'(v) - ip_x100);
   assign frt_prod = 15'(fr) * 15'd205;
   assign fr_tens  = frt_prod[14:11];
   assign ft_x10   = 8'(fr_tens) * 8'd10;
   assign fr_ones  = 4'(8'(fr) - ft_x10);

   always_comb begin
      if (ip >= 5'd20)      ip_tens = 4'd2;
      else if (ip >= 5'd10) ip_tens = 4'd1;
      else                  ip_tens = 4'd0;
      ip_ones = 4'(ip - 5'(ip_tens) * 5'd10);
   end

   always_comb begin
      volts.seg[0] = (ip_tens == 4'd0) ? bmsd_pkg::SEG_BLANK : bmsd_pkg::digit_seg(ip_tens);
      volts.seg[1] = bmsd_pkg::digit_seg(ip_ones) | bmsd_pkg::SEG_DP;
      volts.seg[2] = bmsd_pkg::digit_seg(fr_tens);
      volts.seg[3] = bmsd_pkg::digit_seg(fr_ones);
      volts.mask   = 4'hF;
   end

   always_comb begin
      disp = '0;
      case (screen)
         bmsd_pkg::SCR_ALL: begin
            disp.seg = {bmsd_pkg::SEG_BLANK, bmsd_pkg::SEG_L, bmsd_pkg::SEG_L,
                        bmsd_pkg::SEG_A};
            disp.mask = 4'b0111;
         end
         bmsd_pkg::SCR_CEL1: begin
            disp.seg = {bmsd_pkg::digit_seg(4'd1), bmsd_pkg::SEG_L, bmsd_pkg::SEG_E,
                        bmsd_pkg::SEG_C};
            disp.mask = 4'b1111;
         end
         bmsd_pkg::SCR_CEL2: begin
            disp.seg = {bmsd_pkg::digit_seg(4'd2), bmsd_pkg::SEG_L, bmsd_pkg::SEG_E,
                        bmsd_pkg::SEG_C};
            disp.mask = 4'b1111;
         end
         bmsd_pkg::SCR_CEL3: begin
            disp.seg = {bmsd_pkg::digit_seg(4'd3), bmsd_pkg::SEG_L, bmsd_pkg::SEG_E,
                        bmsd_pkg::SEG_C};
            disp.mask = 4'b1111;
         end
         bmsd_pkg::SCR_PACK,
         bmsd_pkg::SCR_CELL1,
         bmsd_pkg::SCR_CELL2,
         bmsd_pkg::SCR_CELL3: disp = volts;
         bmsd_pkg::SCR_ON: begin
            disp.seg = {bmsd_pkg::SEG_BLANK, bmsd_pkg::SEG_BLANK, bmsd_pkg::SEG_N,
                        bmsd_pkg::digit_seg(4'd0)};
            disp.mask = 4'b0011;
         end
         bmsd_pkg::SCR_NET: begin
            if (net_sw) begin
               disp.seg = {bmsd_pkg::SEG_BLANK, bmsd_pkg::SEG_C,
                           bmsd_pkg::digit_seg(4'd0), bmsd_pkg::SEG_L};
            end else begin
               disp.seg = {bmsd_pkg::SEG_BLANK, bmsd_pkg::SEG_E,
                           bmsd_pkg::digit_seg(4'd1), bmsd_pkg::SEG_P};
            end
            disp.mask = 4'b0111;
         end
         default: disp = '0;
      endcase
   end

endmodule

@@ rtl/battery_monitor_seven_segment_display_core.sv @@
// Battery monitor display core. Every request is one millisecond tick with three
// cumulative ADC taps and the network switch; every request yields exactly one
// response with the four segment patterns, digit mask and screen index of the
// current screen (taken from the state before the tick), plus the alarm and the
// latched cell and pack centivolts after the tick. One request per cycle is
// sustained: a request is registered, converted and displayed by single-cycle
// logic and written to the response register, so throughput is set only by
// rsp_tready. Registers are to be written through the csr port only while no
// request is in flight; the block itself does not enforce this.
module battery_monitor_seven_segment_display_core #(
   parameter int ADC_FULL_SCALE = bmsd_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] adc_tap1, [19:10] adc_tap2, [29:20] adc_tap3, [30] net_sel
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] seg_digit0, [15:8] seg_digit1, [23:16] seg_digit2, [31:24] seg_digit3,
   // [35:32] digit_mask, [36] buzzer_on, [40:37] screen_index, [52:41] cell1_cv,
   // [64:53] cell2_cv, [76:65] cell3_cv, [87:77] pack_cv
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   logic        in_valid_ff;
   logic [30:0] in_data_ff;
   logic        rsp_valid_ff;
   logic [87:0] rsp_data_ff;
   logic        adv;

   logic [10:0] low_cell_ff;
   logic [15:0] meas_period_ff;
   logic [15:0] scr_period_ff;

   logic [3:0]  scr_ff, scr_in;
   logic [15:0] scr_ms_ff, scr_ms_in;
   logic [15:0] meas_ms_ff, meas_ms_in;
   logic signed [11:0] cell1_ff, cell2_ff, cell3_ff;
   logic signed [11:0] cell1_in, cell2_in, cell3_in;
   logic        alarm_ff, alarm_in;

   logic [15:0] scr_elapsed, meas_elapsed;
   logic        scr_fire, meas_fire;
   logic [10:0] t1, t2, t3;
   logic signed [12:0] thr;
   logic [12:0] pack_now_sum, pack_next_sum;
   logic [87:0] rsp_data_in;
   bmsd_pkg::disp_type disp;

   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (!rsp_valid_ff || rsp_tready) rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_data_ff <= req_tdata[30:0];
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_cell_ff    <= bmsd_pkg::LOW_CELL_RST;
         meas_period_ff <= bmsd_pkg::MEASURE_RST;
         scr_period_ff  <= bmsd_pkg::SCREEN_RST;
      end else if (csr_we) begin
         case (csr_addr)
            bmsd_pkg::CSR_LOW_CELL: low_cell_ff    <= csr_wdata[10:0];
            bmsd_pkg::CSR_MEASURE:  meas_period_ff <= csr_wdata;
            bmsd_pkg::CSR_SCREEN:   scr_period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   bmsd_tap_conv #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_tap1 (
      .raw(in_data_ff[9:0]),   .cv(t1));
   bmsd_tap_conv #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_tap2 (
      .raw(in_data_ff[19:10]), .cv(t2));
   bmsd_tap_conv #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_tap3 (
      .raw(in_data_ff[29:20]), .cv(t3));

   // cells always sum to the pack tap, 0..2047
   assign pack_now_sum = 13'(cell1_ff) + 13'(cell2_ff) + 13'(cell3_ff);

   bmsd_display u_disp (
      .screen (scr_ff),
      .cell1  (cell1_ff),
      .cell2  (cell2_ff),
      .cell3  (cell3_ff),
      .pack   (pack_now_sum[10:0]),
      .net_sw (in_data_ff[30]),
      .disp   (disp)
   );

   // elapsed counters saturate at all ones
   assign scr_elapsed  = (scr_ms_ff == 16'hFFFF) ? 16'hFFFF : scr_ms_ff + 16'd1;
   assign meas_elapsed = (meas_ms_ff == 16'hFFFF) ? 16'hFFFF : meas_ms_ff + 16'd1;
   assign scr_fire     = scr_elapsed > scr_period_ff;
   assign meas_fire    = meas_elapsed > meas_period_ff;
   assign thr          = $signed({2'b00, low_cell_ff});

   always_comb begin
      scr_in     = scr_ff;
      scr_ms_in  = scr_elapsed;
      meas_ms_in = meas_elapsed;
      cell1_in   = cell1_ff;
      cell2_in   = cell2_ff;
      cell3_in   = cell3_ff;
      alarm_in   = alarm_ff;
      if (scr_fire) begin
         scr_in    = (scr_ff >= bmsd_pkg::SCREEN_LAST) ? 4'd0 : scr_ff + 4'd1;
         scr_ms_in = 16'd0;
      end
      if (meas_fire) begin
         cell1_in   = $signed({1'b0, t1});
         cell2_in   = $signed({1'b0, t2}) - $signed({1'b0, t1});
         cell3_in   = $signed({1'b0, t3}) - $signed({1'b0, t2});
         alarm_in   = ($signed({cell1_in[11], cell1_in}) < thr) ||
                      ($signed({cell2_in[11], cell2_in}) < thr) ||
                      ($signed({cell3_in[11], cell3_in}) < thr);
         meas_ms_in = 16'd0;
      end
   end

   assign pack_next_sum = 13'(cell1_in) + 13'(cell2_in) + 13'(cell3_in);

   assign rsp_data_in = {pack_next_sum[10:0], cell3_in, cell2_in, cell1_in, scr_ff,
                         alarm_in, disp.mask, disp.seg[3], disp.seg[2], disp.seg[1],
                         disp.seg[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_ff     <= 4'd0;
         scr_ms_ff  <= 16'd0;
         meas_ms_ff <= 16'd0;
         cell1_ff   <= 12'sd0;
         cell2_ff   <= 12'sd0;
         cell3_ff   <= 12'sd0;
         alarm_ff   <= 1'b0;
      end else if (adv) begin
         scr_ff     <= scr_in;
         scr_ms_ff  <= scr_ms_in;
         meas_ms_ff <= meas_ms_in;
         cell1_ff   <= cell1_in;
         cell2_ff   <= cell2_in;
         cell3_ff   <= cell3_in;
         alarm_ff   <= alarm_in;
      end
   end

   a_screen_range: assert property (@(posedge clock) disable iff (reset)
      scr_ff <= bmsd_pkg::SCREEN_LAST)
      else $error("screen counter out of range");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without response backpressure");

   a_pack_is_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[87:77] ==
         11'(rsp_tdata[52:41] + rsp_tdata[64:53] + rsp_tdata[76:65])))
      else $error("pack field differs from sum of cells");

   a_alarm_on_measure: assert property (@(posedge clock) disable iff (reset)
      (alarm_ff != $past(alarm_ff)) |-> (meas_ms_ff == 16'd0))
      else $error("alarm changed outside a measurement");

endmodule
